/* rtl/aes128_block_encrypt_top_macros.svh */
// Assertion macros for the AES-128 block encryption RTL.
`ifndef AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AES_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define AES_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/aes128_pkg.sv */
// Package with payload types, register indexes and AES round functions.
`default_nettype none
package aes128_pkg;

   localparam int unsigned ROUNDS      = 10;
   localparam int unsigned BLOCK_BYTES = 16;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  valid_bytes;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_payload_type;

   localparam logic [0:255][7:0] SBOX = {
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   // Round constants for rounds 1 to 10, first round at index 0.
   localparam logic [0:ROUNDS-1][7:0] RCON = {
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
      return s[127 - 8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes followed by ShiftRows; byte 4c+r takes byte 4((c+r)&3)+r.
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = get_byte(s, 4*c);
         a1  = get_byte(s, 4*c + 1);
         a2  = get_byte(s, 4*c + 2);
         a3  = get_byte(s, 4*c + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 8*(4*c)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // One step of the AES-128 key schedule: four new words from the last four.
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w3 = k[31:0];
      t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      return {w0, w1, w2, w2 ^ w3};
   endfunction

endpackage
`default_nettype wire

/* rtl/aes128_block_encrypt_top.sv */
// Top level of the pipelined AES-128 block encryption core.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    req_payload_type (block, valid_bytes)
//   rsp_      out        rsp_valid/stall    rsp_payload_type (ciphertext)
//   csr_      in         csr_write_en       key_high (index 0), key_low (index 1)
//
// Eleven register stages: the masked block with the first key add, then one stage
// per round; each but the last holds its own round key, made from the previous one.
// A block enters every cycle unless the pipe holds; rsp_valid marks the last stage.
// Reset clears the valid bits and both key registers.
// When the output stage holds a transaction under rsp_stall, the whole pipe holds.
`default_nettype none
`include "aes128_block_encrypt_top_macros.svh"
module aes128_block_encrypt_top
   import aes128_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_write_en,
   input  wire logic [1:0]      csr_index,
   input  wire logic [63:0]     csr_wdata
);

   logic [63:0]  key_high_ff, key_low_ff;
   logic [127:0] state_ff [0:ROUNDS];
   logic [127:0] state_in [0:ROUNDS];
   logic [127:0] rkey_ff  [0:ROUNDS-1];
   logic [127:0] rkey_in  [0:ROUNDS];
   logic [ROUNDS:0] valid_ff;
   logic            advance;
   logic [127:0]    masked;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance   = !(valid_ff[ROUNDS] && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      masked = {req_data.block_high, req_data.block_low};
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (5'(i) >= req_data.valid_bytes) begin
            masked[127 - 8*i -: 8] = 8'h00;
         end
      end
      state_in[0] = masked ^ {key_high_ff, key_low_ff};
      rkey_in[0]  = {key_high_ff, key_low_ff};
   end

   for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
      always_comb begin
         rkey_in[r] = next_key(rkey_ff[r-1], RCON[r-1]);
         if (r < ROUNDS) begin
            state_in[r] = mix_cols(sub_shift(state_ff[r-1])) ^ rkey_in[r];
         end else begin
            state_in[r] = sub_shift(state_ff[r-1]) ^ rkey_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ROUNDS-1:0], req_valid};
      end
   end

   // The last round key is used combinationally and never stored.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= ROUNDS; s++) begin
            state_ff[s] <= state_in[s];
         end
         for (int s = 0; s < ROUNDS; s++) begin
            rkey_ff[s] <= rkey_in[s];
         end
      end
   end

   assign rsp_valid            = valid_ff[ROUNDS];
   assign rsp_data.cipher_high = state_ff[ROUNDS][127:64];
   assign rsp_data.cipher_low  = state_ff[ROUNDS][63:0];

   `AES_ASSERT_SAME(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   `AES_ASSERT_NEXT(a_enter, clock, reset, req_valid && !req_stall, valid_ff[0])
   `AES_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
                    $countones(valid_ff) == $past($countones(valid_ff)))

endmodule
`default_nettype wire

/* verif/aes128_block_encrypt_top_tb.sv */
// Testbench for the AES-128 block encryption core: directed table, then random blocks.
`default_nettype none
module aes128_block_encrypt_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aes128_pkg::*;

   localparam int unsigned NUM_RANDOM = 400;
   localparam int unsigned LATENCY    = 11;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b1;
   rsp_payload_type rsp_data;
   logic            csr_write_en = 1'b0;
   logic [1:0]      csr_index = '0;
   logic [63:0]     csr_wdata = '0;

   aes128_block_encrypt_top i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write_en, .csr_index, .csr_wdata
   );

   always #2 clock = ~clock;

   // Key as the predictor sees it.
   logic [63:0] model_key_high = '0;
   logic [63:0] model_key_low  = '0;

   rsp_payload_type cipher_queue[$];
   int unsigned     error_count = 0;
   bit              no_idle = 1'b0;
   bit              hold_rsp = 1'b0;

   logic [7:0] sbox_lut[256];

   function automatic logic [7:0] gmul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // The S-box is built from the field inverse, independent of the RTL table.
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc ^= a;
         a = gmul2(a);
      end
      return acc;
   endfunction

   initial begin
      logic [7:0] inv, r;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256 && x != 0; y++) begin
            if (gmul(x[7:0], y[7:0]) == 8'h01) begin
               inv = y[7:0];
               break;
            end
         end
         r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sbox_lut[x] = r;
      end
   end

   function automatic rsp_payload_type encrypt_block(input req_payload_type item);
      logic [7:0] st[16], tmp[16], w[44][4], t[4], rc, first, a0, a1, a2, a3, all;
      rsp_payload_type res;
      for (int i = 0; i < 8; i++) begin
         st[i]     = item.block_high[63 - 8*i -: 8];
         st[8 + i] = item.block_low[63 - 8*i -: 8];
         w[i/4][i%4]       = model_key_high[63 - 8*i -: 8];
         w[2 + i/4][i%4]   = model_key_low[63 - 8*i -: 8];
      end
      for (int i = 0; i < 16; i++) if (i >= item.valid_bytes) st[i] = '0;
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) t[j] = w[i-1][j];
         if (i % 4 == 0) begin
            first = t[0];
            t[0] = sbox_lut[t[1]] ^ rc;
            t[1] = sbox_lut[t[2]];
            t[2] = sbox_lut[t[3]];
            t[3] = sbox_lut[first];
            rc = gmul2(rc);
         end
         for (int j = 0; j < 4; j++) w[i][j] = w[i-4][j] ^ t[j];
      end
      for (int i = 0; i < 16; i++) st[i] ^= w[i/4][i%4];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) tmp[4*c + r] = sbox_lut[st[4*((c + r) % 4) + r]];
         st = tmp;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
               st[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
               st[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
               st[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= w[4*rnd + i/4][i%4];
      end
      for (int i = 0; i < 8; i++) begin
         res.cipher_high[63 - 8*i -: 8] = st[i];
         res.cipher_low[63 - 8*i -: 8]  = st[8 + i];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Directed rows; when has_known is set, the known column is the answer to check too.
   typedef struct {
      logic [63:0] key_high, key_low;
      req_payload_type item;
      bit          has_known;
      rsp_payload_type known;
   } directed_row_type;

   directed_row_type directed_rows[$];

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_KEY_HIGH) model_key_high = value;
      else if (idx == CSR_KEY_LOW) model_key_low = value;
   endtask

   // Write to an index the block does not decode; the key must not change.
   task automatic csr_write_unknown(input logic [63:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = 2'd3;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic drain;
      while (cipher_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Sender: called at a falling edge, returns at a falling edge after acceptance.
   task automatic send_block(input req_payload_type item);
      while (!no_idle && $urandom_range(99) < 38) @(negedge clock);
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cipher_queue.push_back(encrypt_block(item));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // A run of random blocks; valid stays high between them unless an idle gap is drawn.
   task automatic send_burst(input int unsigned count);
      req_payload_type item;
      for (int n = 0; n < count; n++) begin
         item.block_high  = {$urandom, $urandom};
         item.block_low   = {$urandom, $urandom};
         item.valid_bytes = ($urandom_range(3) == 0) ? 5'($urandom) : 5'd16;
         if (no_idle || $urandom_range(99) >= 38) begin
            req_valid = 1'b1;
            req_data  = item;
            @(posedge clock);
            while (req_stall) @(posedge clock);
            cipher_queue.push_back(encrypt_block(item));
            @(negedge clock);
            req_valid = 1'b0;
         end else begin
            send_block(item);
         end
      end
   endtask

   // Receiver and checker.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_queue.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.cipher_high, '0);
         end else begin
            want = cipher_queue.pop_front();
            if (rsp_data.cipher_high !== want.cipher_high)
               report_mismatch("cipher_high", rsp_data.cipher_high, want.cipher_high);
            if (rsp_data.cipher_low !== want.cipher_low)
               report_mismatch("cipher_low", rsp_data.cipher_low, want.cipher_low);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_rsp) rsp_stall <= 1'b1;
      else if (no_idle) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 38);
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      directed_row_type row;
      rsp_payload_type  known_zero;

      // FIPS-197 appendix C.1 vector.
      row.key_high = 64'h0001020304050607; row.key_low = 64'h08090a0b0c0d0e0f;
      row.item = '{64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16};
      row.has_known = 1'b1; row.known = '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
      directed_rows.push_back(row);
      // FIPS-197 appendix B vector.
      row.key_high = 64'h2b7e151628aed2a6; row.key_low = 64'habf7158809cf4f3c;
      row.item = '{64'h3243f6a8885a308d, 64'h313198a2e0370734, 5'd16};
      row.known = '{64'h3925841d02dc09fb, 64'hdc118597196a0b32};
      directed_rows.push_back(row);
      // All-zero key and block.
      row.key_high = '0; row.key_low = '0;
      row.item = '{'0, '0, 5'd16};
      known_zero = '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
      row.known = known_zero;
      directed_rows.push_back(row);
      // Zero valid bytes blanks the block, so the answer is the zero-block one.
      row.item = '{'1, '1, 5'd0};
      directed_rows.push_back(row);
      row.has_known = 1'b0;
      row.key_high = '1; row.key_low = '1;
      for (int v = 1; v <= 17; v++) begin
         row.item = '{'1, '1, 5'(v)};
         directed_rows.push_back(row);
      end
      row.item = '{'1, '1, 5'd31};
      directed_rows.push_back(row);
      row.key_high = 64'haaaa5555aaaa5555; row.key_low = 64'h5555aaaa5555aaaa;
      row.item = '{64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd9};
      directed_rows.push_back(row);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.key_high !== model_key_high || row.key_low !== model_key_low) begin
            drain();
            csr_write(CSR_KEY_HIGH, row.key_high);
            csr_write(CSR_KEY_LOW, row.key_low);
         end
         if (row.has_known && encrypt_block(row.item) !== row.known) begin
            $display("predictor disagrees with known answer in row %0d", i);
            error_count++;
         end
         send_block(row.item);
      end

      drain();
      csr_write_unknown('1);

      // Random phases with several keys; one phase without idling, one with a long hold.
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         csr_write(CSR_KEY_HIGH, {$urandom, $urandom});
         csr_write(CSR_KEY_LOW, {$urandom, $urandom});
         no_idle = (phase == 2);
         if (phase == 3) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (60) @(negedge clock);
                  hold_rsp = 1'b0;
               end
               send_burst(NUM_RANDOM / 6);
            join
         end else begin
            send_burst(NUM_RANDOM / 6);
         end
         no_idle = 1'b0;
      end

      fork
         begin
            while (cipher_queue.size() != 0) @(negedge clock);
            repeat (LATENCY + 4) @(negedge clock);
         end
         begin
            #200_000;
         end
      join_any
      disable fork;
      if (error_count == 0 && cipher_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
